>>> src/spe_pkg.sv
// Shared types and constants for the sigmoid polynomial spectrum evaluator.
`default_nettype none
package spe_pkg;

  // Default fraction bits of the coefficient format
  localparam int unsigned COEF_FRAC_BITS_DEF = 32;

  // Band ends as Q10.6 wavelength codes (360 nm and 830 nm)
  localparam logic [15:0] LAMBDA_LO = 16'd23040;
  localparam logic [15:0] LAMBDA_HI = 16'd53120;

  // Output scale: 65536 means 1.0
  localparam logic [16:0] HALF_Q16 = 17'd32768;
  localparam logic [16:0] ONE_Q16  = 17'd65536;

  // Pipeline depths
  localparam int unsigned SQRT_STEPS = 31;  // root bits of the square root
  localparam int unsigned DIV_STEPS  = 16;  // quotient bits of the sigmoid divide
  localparam int unsigned VDIV_STEPS = 16;  // quotient bits of the vertex divide
  localparam int unsigned EVAL_LAT   = 6 + SQRT_STEPS + DIV_STEPS + 1;

  // Input request
  typedef struct packed {
    logic signed [47:0] coef_c0;
    logic signed [47:0] coef_c1;
    logic signed [47:0] coef_c2;
    logic        [15:0] wavelength;
  } in_t;

  // Result
  typedef struct packed {
    logic [16:0] value;
    logic [16:0] max_value;
  } out_t;

endpackage
`default_nettype wire

>>> src/sigmoid_polynomial_spectrum_eval.sv
// Top level: sigmoid polynomial spectrum evaluator with band maximum.
// Each request carries c0, c1, c2 (signed Q.F) and a Q10.6 wavelength. The
// block returns s(p) at that wavelength and the largest s over 360..830 nm,
// taken at both band ends and at the parabola vertex when it lies in band.
// Both channels use valid/stall; a request moves when valid is high and stall
// is low. Results leave from an output register.
// Throughput: one request per cycle, no gaps between independent requests,
// while the output is not stalled. From an accepted request to the result,
// the vertex divide (16 stages) runs first, then four evaluation pipelines
// run side by side; each spends 31 stages in its square root, 16 in divide.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_stall_o rises in the same cycle; nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty after reset and accepts
// a request in the first cycle.
`default_nettype none
module sigmoid_polynomial_spectrum_eval #(
  parameter int unsigned COEF_FRAC_BITS = spe_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire spe_pkg::in_t  in_data_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output spe_pkg::out_t      out_data_o
);

  localparam int unsigned VDS = spe_pkg::VDIV_STEPS;
  localparam int unsigned ELAT = spe_pkg::EVAL_LAT;
  localparam int unsigned TOT = 1 + 1 + VDS + 1 + ELAT;

  logic en;
  logic out_valid_q;
  spe_pkg::out_t out_q;

  // Advance everything unless a result waits on a stalled receiver
  assign en = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Valid bits, one per stage
  logic [TOT-1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[TOT-2:0], in_valid_i};
    end
  end

  // Input register
  spe_pkg::in_t in_q;
  always_ff @(posedge clk_i) begin
    if (en) begin
      in_q <= in_data_i;
    end
  end

  // Vertex setup: numerator |c1|*128 + |c2|, divisor 2|c2|
  logic [47:0] mn, md;
  logic [54:0] vnum;
  logic [48:0] vden;
  logic        vflag, vover;
  assign mn    = in_q.coef_c1[47] ? 48'(-in_q.coef_c1) : 48'(in_q.coef_c1);
  assign md    = in_q.coef_c2[47] ? 48'(-in_q.coef_c2) : 48'(in_q.coef_c2);
  assign vnum  = (55'(mn) << 7) + 55'(md);
  assign vden  = {md, 1'b0};
  assign vflag = (in_q.coef_c2 != '0) && (in_q.coef_c1 != '0) &&
                 (in_q.coef_c1[47] != in_q.coef_c2[47]);
  assign vover = 65'(vnum) >= (65'(vden) << VDS);

  logic [54:0]   vrem_q [VDS+1];
  logic [48:0]   vden_q [VDS+1];
  logic [15:0]   vquo_q [VDS+1];
  logic          vok_q  [VDS+1];
  spe_pkg::in_t  vcf_q  [VDS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      vrem_q[0] <= vnum;
      vden_q[0] <= vden;
      vquo_q[0] <= '0;
      vok_q[0]  <= vflag && !vover;
      vcf_q[0]  <= in_q;
    end
  end

  // Vertex divide, one quotient bit per stage
  for (genvar k = 0; k < VDS; k++) begin : g_vdiv
    localparam int unsigned B = VDS - 1 - k;
    logic [63:0] shd;
    logic        take;
    assign shd  = 64'(vden_q[k]) << B;
    assign take = 64'(vrem_q[k]) >= shd;
    always_ff @(posedge clk_i) begin
      if (en) begin
        vrem_q[k+1] <= take ? 55'(64'(vrem_q[k]) - shd) : vrem_q[k];
        vquo_q[k+1] <= take ? (vquo_q[k] | (16'd1 << B)) : vquo_q[k];
        vden_q[k+1] <= vden_q[k];
        vok_q[k+1]  <= vok_q[k];
        vcf_q[k+1]  <= vcf_q[k];
      end
    end
  end

  // Band check on the vertex, then launch the four evaluations
  logic         vuse_d;
  spe_pkg::in_t b_cf_q;
  logic [15:0]  b_v6_q;
  logic [ELAT:0] vuse_q;
  assign vuse_d = vok_q[VDS] && (vquo_q[VDS] >= spe_pkg::LAMBDA_LO) &&
                  (vquo_q[VDS] <= spe_pkg::LAMBDA_HI);
  always_ff @(posedge clk_i) begin
    if (en) begin
      b_cf_q <= vcf_q[VDS];
      b_v6_q <= vquo_q[VDS];
      vuse_q <= {vuse_q[ELAT-1:0], vuse_d};
    end
  end

  logic [16:0] e_val, e_lo, e_hi, e_vtx;

  spe_eval #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_eval_val (
    .clk_i, .en_i(en), .c0_i(b_cf_q.coef_c0), .c1_i(b_cf_q.coef_c1),
    .c2_i(b_cf_q.coef_c2), .lambda_i(b_cf_q.wavelength), .value_o(e_val)
  );
  spe_eval #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_eval_lo (
    .clk_i, .en_i(en), .c0_i(b_cf_q.coef_c0), .c1_i(b_cf_q.coef_c1),
    .c2_i(b_cf_q.coef_c2), .lambda_i(spe_pkg::LAMBDA_LO), .value_o(e_lo)
  );
  spe_eval #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_eval_hi (
    .clk_i, .en_i(en), .c0_i(b_cf_q.coef_c0), .c1_i(b_cf_q.coef_c1),
    .c2_i(b_cf_q.coef_c2), .lambda_i(spe_pkg::LAMBDA_HI), .value_o(e_hi)
  );
  spe_eval #(.COEF_FRAC_BITS(COEF_FRAC_BITS)) u_eval_vtx (
    .clk_i, .en_i(en), .c0_i(b_cf_q.coef_c0), .c1_i(b_cf_q.coef_c1),
    .c2_i(b_cf_q.coef_c2), .lambda_i(b_v6_q), .value_o(e_vtx)
  );

  // Take the band maximum
  logic [16:0] mx_ends, mx_all;
  assign mx_ends = (e_hi > e_lo) ? e_hi : e_lo;
  assign mx_all  = (vuse_q[ELAT] && (e_vtx > mx_ends)) ? e_vtx : mx_ends;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[TOT-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q.value     <= e_val;
      out_q.max_value <= mx_all;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Input stalls only behind a stalled, waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a waiting result");

  // A result appears only after the last stage held a valid request
  a_out_origin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(vld_q[TOT-1]))
    else $error("result without a request behind it");

  // A valid last stage moves into the output when not stalled
  a_out_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q[TOT-1] && !in_stall_o) |=> out_valid_o)
    else $error("request dropped at the output");

  // Both results stay within 0..1.0
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_data_o.value <= spe_pkg::ONE_Q16) &&
                     (out_data_o.max_value <= spe_pkg::ONE_Q16)))
    else $error("result beyond 1.0");

endmodule
`default_nettype wire

>>> src/spe_eval.sv
// One pipelined evaluation of the sigmoid of a quadratic at a given wavelength.
`default_nettype none
module spe_eval #(
  parameter int unsigned COEF_FRAC_BITS = spe_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               en_i,
  input  wire logic signed [47:0] c0_i,
  input  wire logic signed [47:0] c1_i,
  input  wire logic signed [47:0] c2_i,
  input  wire logic        [15:0] lambda_i,
  output logic             [16:0] value_o
);

  localparam int unsigned SQS = spe_pkg::SQRT_STEPS;
  localparam int unsigned DVS = spe_pkg::DIV_STEPS;
  localparam logic signed [76:0] CAP_P = 77'sd1 <<< 62;
  localparam logic signed [76:0] CAP_N = -CAP_P;
  localparam logic [57:0] PLIM = 58'd1 << (COEF_FRAC_BITS + 10);

  // Stage 1: c2 * l
  logic signed [64:0] prod2_d, prod2_q;
  logic signed [47:0] c0_1_q, c1_1_q;
  logic        [15:0] l_1_q;
  assign prod2_d = c2_i * $signed({1'b0, lambda_i});
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod2_q <= prod2_d;
      c0_1_q  <= c0_i;
      c1_1_q  <= c1_i;
      l_1_q   <= lambda_i;
    end
  end

  // Stage 2: floor to Q.F and add c1
  logic signed [59:0] t_d, t_q;
  logic signed [47:0] c0_2_q;
  logic        [15:0] l_2_q;
  assign t_d = 60'(prod2_q >>> 6) + 60'(c1_1_q);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_q    <= t_d;
      c0_2_q <= c0_1_q;
      l_2_q  <= l_1_q;
    end
  end

  // Stage 3: t * l
  logic signed [76:0] prod1_d, prod1_q;
  logic signed [47:0] c0_3_q;
  assign prod1_d = t_q * $signed({1'b0, l_2_q});
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod1_q <= prod1_d;
      c0_3_q  <= c0_2_q;
    end
  end

  // Stage 4: overflow check on t*l, floor and add c0
  logic signed [57:0] p_d, p_q;
  logic               sata_d, sata_q, sata_hi_q;
  assign sata_d = (prod1_q > CAP_P) || (prod1_q < CAP_N);
  assign p_d    = 58'(prod1_q >>> 6) + 58'(c0_3_q);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q       <= p_d;
      sata_q    <= sata_d;
      sata_hi_q <= !prod1_q[76];
    end
  end

  // Stage 5: magnitude, range check, scale to Q.20
  logic [57:0] mp;
  logic [29:0] a_d;
  logic [29:0] a_5_q;
  logic        neg_5_q, sat_5_q, sathi_5_q;
  assign mp = p_q[57] ? 58'(-p_q) : 58'(p_q);
  if (COEF_FRAC_BITS >= 20) begin : g_shr
    assign a_d = 30'(mp >> (COEF_FRAC_BITS - 20));
  end else begin : g_shl
    assign a_d = 30'(mp << (20 - COEF_FRAC_BITS));
  end
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_5_q     <= a_d;
      neg_5_q   <= p_q[57];
      sat_5_q   <= sata_q || (mp >= PLIM);
      sathi_5_q <= sata_q ? sata_hi_q : !p_q[57];
    end
  end

  // Stage 6: a*a + 1.0^2
  logic [61:0] sq_d;
  assign sq_d = 62'(a_5_q) * 62'(a_5_q) + (62'd1 << 40);

  // Square root pipeline, one root bit per stage
  logic [61:0] srem_q  [SQS+1];
  logic [30:0] sroot_q [SQS+1];
  logic [29:0] sa_q    [SQS+1];
  logic        sneg_q  [SQS+1];
  logic        ssat_q  [SQS+1];
  logic        sshi_q  [SQS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      srem_q[0]  <= sq_d;
      sroot_q[0] <= '0;
      sa_q[0]    <= a_5_q;
      sneg_q[0]  <= neg_5_q;
      ssat_q[0]  <= sat_5_q;
      sshi_q[0]  <= sathi_5_q;
    end
  end

  for (genvar k = 0; k < SQS; k++) begin : g_sqrt
    localparam int unsigned B = SQS - 1 - k;
    logic [61:0] trial;
    logic        take;
    assign trial = (62'(sroot_q[k]) << (B + 1)) + (62'd1 << (2 * B));
    assign take  = srem_q[k] >= trial;
    // Set this root bit when the trial fits
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        srem_q[k+1]  <= take ? srem_q[k] - trial : srem_q[k];
        sroot_q[k+1] <= take ? (sroot_q[k] | (31'd1 << B)) : sroot_q[k];
        sa_q[k+1]    <= sa_q[k];
        sneg_q[k+1]  <= sneg_q[k];
        ssat_q[k+1]  <= ssat_q[k];
        sshi_q[k+1]  <= sshi_q[k];
      end
    end
  end

  // Divide pipeline: h = (a*2^16 + d) / (2d), one quotient bit per stage
  logic [46:0] drem   [DVS+1];
  logic [31:0] dden   [DVS+1];
  logic [15:0] dquo   [DVS+1];
  logic        dneg   [DVS+1];
  logic        dsat   [DVS+1];
  logic        dshi   [DVS+1];

  assign drem[0] = (47'(sa_q[SQS]) << 16) + 47'(sroot_q[SQS]);
  assign dden[0] = {sroot_q[SQS], 1'b0};
  assign dquo[0] = '0;
  assign dneg[0] = sneg_q[SQS];
  assign dsat[0] = ssat_q[SQS];
  assign dshi[0] = sshi_q[SQS];

  for (genvar k = 0; k < DVS; k++) begin : g_div
    localparam int unsigned B = DVS - 1 - k;
    logic [46:0] shd;
    logic        take;
    assign shd  = 47'(dden[k]) << B;
    assign take = drem[k] >= shd;
    logic [46:0] rem_q;
    logic [31:0] den_q;
    logic [15:0] quo_q;
    logic        neg_q, sat_q, shi_q;
    // Subtract the shifted divisor when it fits
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q <= take ? drem[k] - shd : drem[k];
        quo_q <= take ? (dquo[k] | (16'd1 << B)) : dquo[k];
        den_q <= dden[k];
        neg_q <= dneg[k];
        sat_q <= dsat[k];
        shi_q <= dshi[k];
      end
    end
    assign drem[k+1] = rem_q;
    assign dden[k+1] = den_q;
    assign dquo[k+1] = quo_q;
    assign dneg[k+1] = neg_q;
    assign dsat[k+1] = sat_q;
    assign dshi[k+1] = shi_q;
  end

  // Final stage: saturate or center around one half
  logic [16:0] value_d;
  always_comb begin
    if (dsat[DVS]) begin
      value_d = dshi[DVS] ? spe_pkg::ONE_Q16 : 17'd0;
    end else if (dneg[DVS]) begin
      value_d = spe_pkg::HALF_Q16 - 17'(dquo[DVS]);
    end else begin
      value_d = spe_pkg::HALF_Q16 + 17'(dquo[DVS]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      value_o <= value_d;
    end
  end

endmodule
`default_nettype wire
